>>> sv/wsme_pkg.sv
// wsme_pkg: shared types, constants and helpers for the masked frame encoder
// payload structs, queue entry format and header byte codes
// no dependencies
package wsme_pkg;

  localparam logic       OP_START      = 1'b0;
  localparam logic [3:0] OPC_CLOSE     = 4'h8;
  localparam logic [3:0] OPC_PING      = 4'h9;
  localparam logic [3:0] OPC_PONG      = 4'hA;
  localparam logic [7:0] MASK_BIT      = 8'h80;
  localparam logic [6:0] LEN_CODE_MID  = 7'h7E;
  localparam logic [6:0] LEN_CODE_LONG = 7'h7F;
  localparam int unsigned LEN_SHORT_MAX = 125;
  localparam int unsigned LEN_MID_MAX   = 32'h0000_FFFF;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_KEY_SHORT  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LAST_SHORT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_KEY_MID    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LAST_MID   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LEN_LONG   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_KEY_LONG   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST_LONG  = 4'd13;

  typedef struct packed {
    logic        op;
    logic [3:0]  opcode;
    logic        final_fragment;
    logic [31:0] payload_length;
    logic [31:0] frame_key;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_REJECT,
    KIND_HDR_SHORT,
    KIND_HDR_MID,
    KIND_HDR_LONG
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  byte0;
    logic        last;
    logic [31:0] length;
    logic [31:0] key;
  } q_entry_t;

  // byte idx of a word, most significant first
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> sv/wsme_front.sv
// wsme_front: accepts input transfers, tracks the open frame and classifies items
// data bytes are masked here; headers and rejects go to the queue for expansion
// depends on wsme_pkg
module wsme_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsme_pkg::in_item_t  in_data,
  output logic                push_valid,
  output wsme_pkg::q_entry_t  push_entry,
  input  logic                q_full
);
  import wsme_pkg::*;

  localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  logic [LW-1:0] bytes_left_r, bytes_left_nxt;
  logic [31:0]   held_key_r, held_key_nxt;
  logic [1:0]    key_index_r, key_index_nxt;

  logic          accept;
  logic [LW-1:0] len_b;
  logic [31:0]   len32;
  logic          is_ctrl;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign len_b    = in_data.payload_length[LW-1:0];
  assign len32    = 32'(len_b);

  always_comb begin
    case (in_data.opcode)
      OPC_CLOSE, OPC_PING, OPC_PONG: is_ctrl = 1'b1;
      default:                       is_ctrl = 1'b0;
    endcase
  end

  always_comb begin
    bytes_left_nxt    = bytes_left_r;
    held_key_nxt      = held_key_r;
    key_index_nxt     = key_index_r;
    push_valid        = 1'b0;
    push_entry.kind   = KIND_DATA;
    push_entry.byte0  = {in_data.final_fragment, 3'b000, in_data.opcode};
    push_entry.last   = 1'b0;
    push_entry.length = len32;
    push_entry.key    = in_data.frame_key;
    if (accept) begin
      if (in_data.op == OP_START) begin
        bytes_left_nxt = '0;
        key_index_nxt  = '0;
        push_valid     = 1'b1;
        if (is_ctrl && (!in_data.final_fragment || len32 > 32'(LEN_SHORT_MAX))) begin
          push_entry.kind = KIND_REJECT;
        end else begin
          held_key_nxt   = in_data.frame_key;
          bytes_left_nxt = len_b;
          if (len32 <= 32'(LEN_SHORT_MAX)) begin
            push_entry.kind = KIND_HDR_SHORT;
          end else if (len32 <= 32'(LEN_MID_MAX)) begin
            push_entry.kind = KIND_HDR_MID;
          end else begin
            push_entry.kind = KIND_HDR_LONG;
          end
        end
      end else if (bytes_left_r != '0) begin
        push_valid       = 1'b1;
        push_entry.kind  = KIND_DATA;
        push_entry.byte0 = in_data.payload_byte ^ word_byte(held_key_r, key_index_r);
        push_entry.last  = (bytes_left_r == LW'(1));
        bytes_left_nxt   = bytes_left_r - LW'(1);
        key_index_nxt    = key_index_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      held_key_r   <= '0;
      key_index_r  <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      held_key_r   <= held_key_nxt;
      key_index_r  <= key_index_nxt;
    end
  end

endmodule

>>> sv/wsme_queue.sv
// wsme_queue: short register queue between the front and the back
// holds classified entries so either side may stall on its own
// depends on wsme_pkg
module wsme_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  wsme_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output wsme_pkg::q_entry_t head_entry
);
  import wsme_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push_valid) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

>>> sv/wsme_back.sv
// wsme_back: output sequencer that expands queue entries into frame bytes
// headers take several steps, data and reject entries one; output register at the end
// depends on wsme_pkg
module wsme_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_head_valid,
  input  wsme_pkg::q_entry_t  q_head_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output wsme_pkg::out_item_t out_payload
);
  import wsme_pkg::*;

  logic              busy_r, busy_nxt;
  q_entry_t          cur_r, cur_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_payload_r, out_payload_nxt;

  q_entry_t          src;
  logic [STEP_W-1:0] src_step;
  logic              src_valid;
  logic              advance;
  logic              take;
  out_item_t         gen;
  logic              gen_last;

  assign src       = busy_r ? cur_r : q_head_entry;
  assign src_step  = busy_r ? step_r : '0;
  assign src_valid = busy_r || q_head_valid;
  assign advance   = !out_valid_r || out_ready;
  assign take      = src_valid && advance;
  assign q_pop     = take && !busy_r;

  always_comb begin
    gen.out_byte  = 8'h00;
    gen.frame_end = 1'b0;
    gen.rejected  = 1'b0;
    gen_last      = 1'b1;
    unique case (src.kind)
      KIND_DATA: begin
        gen.out_byte  = src.byte0;
        gen.frame_end = src.last;
      end
      KIND_REJECT: begin
        gen.frame_end = 1'b1;
        gen.rejected  = 1'b1;
      end
      KIND_HDR_SHORT: begin
        gen_last = (src_step == STEP_LAST_SHORT);
        case (src_step)
          4'd0:    gen.out_byte = src.byte0;
          4'd1:    gen.out_byte = MASK_BIT | {1'b0, src.length[6:0]};
          default: gen.out_byte = word_byte(src.key, 2'(src_step - STEP_KEY_SHORT));
        endcase
        gen.frame_end = gen_last && (src.length == '0);
      end
      KIND_HDR_MID: begin
        gen_last = (src_step == STEP_LAST_MID);
        case (src_step)
          4'd0:    gen.out_byte = src.byte0;
          4'd1:    gen.out_byte = MASK_BIT | {1'b0, LEN_CODE_MID};
          4'd2:    gen.out_byte = src.length[15:8];
          4'd3:    gen.out_byte = src.length[7:0];
          default: gen.out_byte = word_byte(src.key, 2'(src_step - STEP_KEY_MID));
        endcase
      end
      KIND_HDR_LONG: begin
        gen_last = (src_step == STEP_LAST_LONG);
        if (src_step == 4'd0) begin
          gen.out_byte = src.byte0;
        end else if (src_step == 4'd1) begin
          gen.out_byte = MASK_BIT | {1'b0, LEN_CODE_LONG};
        end else if (src_step < STEP_LEN_LONG) begin
          gen.out_byte = 8'h00;
        end else if (src_step < STEP_KEY_LONG) begin
          gen.out_byte = word_byte(src.length, 2'(src_step - STEP_LEN_LONG));
        end else begin
          gen.out_byte = word_byte(src.key, 2'(src_step - STEP_KEY_LONG));
        end
      end
      default: begin
        gen_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt        = busy_r;
    cur_nxt         = cur_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r;
    out_payload_nxt = out_payload_r;
    if (take) begin
      out_valid_nxt   = 1'b1;
      out_payload_nxt = gen;
      cur_nxt         = src;
      step_nxt        = src_step + STEP_W'(1);
      busy_nxt        = !gen_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    step_r        <= step_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  a_reject_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_payload_r.rejected) |-> out_payload_r.frame_end)
    else $error("reject transfer without frame end");

  a_busy_header: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.kind == KIND_HDR_SHORT || cur_r.kind == KIND_HDR_MID ||
                cur_r.kind == KIND_HDR_LONG))
    else $error("sequencer busy on a single-byte entry");

  a_busy_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r != '0 && step_r <= STEP_LAST_LONG))
    else $error("header step out of range");

endmodule

>>> sv/websocket_masked_frame_encoder_core.sv
// websocket_masked_frame_encoder_core: top level of the client frame encoder
// front classifier, entry queue and output sequencer
// depends on wsme_pkg, wsme_front, wsme_queue, wsme_back
//
// A start transfer opens a frame and yields its header: the first byte, the
// masked length in 7-, 16- or 64-bit form and the four key bytes, 6, 8 or 14
// output transfers that the output sequencer emits one per cycle unless
// stalled. Each data transfer yields one masked payload byte, and data
// passes at one byte per cycle end to end unless stalled. A refused control
// frame yields a single transfer with frame_end and rejected set. Data with
// no frame open is taken and gives nothing. Inputs are taken every cycle
// while the QUEUE_DEPTH entry queue has room, so input stalls only behind a
// header still being sent or a stalled output. LENGTH_BITS bounds the
// payload length counter; lengths are taken modulo 2^LENGTH_BITS below 32.
module websocket_masked_frame_encoder_core #(
  parameter int LENGTH_BITS = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsme_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wsme_pkg::out_item_t out_payload
);
  import wsme_pkg::*;

  logic     push_valid;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head_entry;

  wsme_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  wsme_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  wsme_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head_valid (q_head_valid),
    .q_head_entry (q_head_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_payload  (out_payload)
  );

endmodule

>>> tb/sv/wsme_frame_checker.sv
// wsme_frame_checker: watches both channels of the masked frame encoder,
// predicts the wire bytes of each input transfer and checks every output transfer
// depends on wsme_pkg
module wsme_frame_checker #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wsme_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wsme_pkg::out_item_t out_payload,
  output int unsigned         mismatches,
  output int unsigned         pending,
  output int unsigned         results_checked,
  output int unsigned         refusals_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsme_pkg::*;

  logic [31:0] bytes_due;
  logic [31:0] key_held;
  logic [1:0]  key_pos;
  out_item_t   wire_bytes_q[$];

  function automatic void push_wire_byte(input logic [7:0] b, input logic e, input logic r);
    out_item_t o;
    o.out_byte  = b;
    o.frame_end = e;
    o.rejected  = r;
    wire_bytes_q.push_back(o);
  endfunction

  function automatic void encode_transfer(input in_item_t it);
    logic [31:0] len;
    logic [7:0]  kb;
    logic        ctrl;
    if (it.op == OP_START) begin
      len = it.payload_length;
      if (LENGTH_BITS < 32) len = len & 32'((64'd1 << LENGTH_BITS) - 64'd1);
      ctrl = (it.opcode == OPC_CLOSE) || (it.opcode == OPC_PING) || (it.opcode == OPC_PONG);
      bytes_due = '0;
      key_pos   = '0;
      if (ctrl && (!it.final_fragment || len > LEN_SHORT_MAX)) begin
        push_wire_byte(8'h00, 1'b1, 1'b1);
      end else begin
        key_held  = it.frame_key;
        bytes_due = len;
        push_wire_byte({it.final_fragment, 3'b000, it.opcode}, 1'b0, 1'b0);
        if (len <= LEN_SHORT_MAX) begin
          push_wire_byte(MASK_BIT | {1'b0, len[6:0]}, 1'b0, 1'b0);
        end else if (len <= LEN_MID_MAX) begin
          push_wire_byte(MASK_BIT | {1'b0, LEN_CODE_MID}, 1'b0, 1'b0);
          push_wire_byte(len[15:8], 1'b0, 1'b0);
          push_wire_byte(len[7:0], 1'b0, 1'b0);
        end else begin
          push_wire_byte(MASK_BIT | {1'b0, LEN_CODE_LONG}, 1'b0, 1'b0);
          repeat (4) push_wire_byte(8'h00, 1'b0, 1'b0);
          for (int i = 0; i < 4; i++) push_wire_byte(len[8*(3-i) +: 8], 1'b0, 1'b0);
        end
        for (int i = 0; i < 4; i++)
          push_wire_byte(it.frame_key[8*(3-i) +: 8], (i == 3) && (len == 0), 1'b0);
      end
    end else if (bytes_due != 0) begin
      kb        = key_held[8*(3-key_pos) +: 8];
      key_pos   = key_pos + 2'd1;
      bytes_due = bytes_due - 32'd1;
      push_wire_byte(it.payload_byte ^ kb, bytes_due == 0, 1'b0);
    end
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wire_bytes_q.delete();
      bytes_due       = '0;
      key_held        = '0;
      key_pos         = '0;
      mismatches      = 0;
      results_checked = 0;
      refusals_seen   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (wire_bytes_q.size() == 0) begin
          log_mismatch($sformatf("unexpected transfer, got byte %02h end %0b rej %0b",
                                 out_payload.out_byte, out_payload.frame_end,
                                 out_payload.rejected));
        end else begin
          want = wire_bytes_q.pop_front();
          results_checked++;
          if (out_payload.rejected === 1'b1) refusals_seen++;
          if (out_payload.out_byte !== want.out_byte ||
              out_payload.frame_end !== want.frame_end ||
              out_payload.rejected !== want.rejected)
            log_mismatch($sformatf("expected byte %02h end %0b rej %0b, got byte %02h end %0b rej %0b",
                                   want.out_byte, want.frame_end, want.rejected,
                                   out_payload.out_byte, out_payload.frame_end,
                                   out_payload.rejected));
        end
      end
      if (in_valid && in_ready) encode_transfer(in_data);
    end
    pending = wire_bytes_q.size();
  end

endmodule

>>> tb/sv/websocket_masked_frame_encoder_core_test.sv
// websocket_masked_frame_encoder_core_test: stimulus, flow control and verdict
// for the masked frame encoder; checking is done by wsme_frame_checker
// depends on wsme_pkg, wsme_frame_checker, websocket_masked_frame_encoder_core
module websocket_masked_frame_encoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsme_pkg::*;

  localparam int         LENGTH_BITS     = 32;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         PHASE_ITEMS     = 42;
  localparam logic       OP_DATA         = ~OP_START;
  localparam logic [3:0] OPC_TEXT        = 4'h1;
  localparam logic [3:0] OPC_BINARY      = 4'h2;
  localparam logic [3:0] OPC_RESERVED_HI = 4'hF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_payload;

  int unsigned chk_mismatches;
  int unsigned chk_pending;
  int unsigned chk_results;
  int unsigned chk_refusals;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          hold_off;
  int unsigned frame_items;

  websocket_masked_frame_encoder_core #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  wsme_frame_checker #(.LENGTH_BITS(LENGTH_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_payload     (out_payload),
    .mismatches      (chk_mismatches),
    .pending         (chk_pending),
    .results_checked (chk_results),
    .refusals_seen   (chk_refusals)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    frame_items++;
  endtask

  task automatic send_start(input logic [3:0] opc, input logic fin, input logic [31:0] len,
                            input logic [31:0] key);
    in_item_t it;
    it                = '0;
    it.op             = OP_START;
    it.opcode         = opc;
    it.final_fragment = fin;
    it.payload_length = len;
    it.frame_key      = key;
    it.payload_byte   = 8'($urandom_range(255));
    offer(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    in_item_t it;
    it                = '0;
    it.op             = OP_DATA;
    it.opcode         = 4'($urandom_range(15));
    it.final_fragment = 1'($urandom_range(1));
    it.payload_length = $urandom;
    it.frame_key      = $urandom;
    it.payload_byte   = b;
    offer(it);
  endtask

  task automatic send_frame(input logic [3:0] opc, input logic fin, input logic [31:0] len,
                            input logic [31:0] key, input int unsigned n_data);
    send_start(opc, fin, len, key);
    repeat (n_data) send_data(8'($urandom_range(255)));
  endtask

  task automatic send_random_frame();
    logic [31:0] len;
    int unsigned n;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65)      len = $urandom_range(12);
    else if (r < 75) len = $urandom_range(125, 13);
    else if (r < 85) len = $urandom_range(32'hFFFF, 126);
    else if (r < 95) len = $urandom_range(32'hFFFF_FFFF, 32'h1_0000);
    else             len = $urandom;
    n = (len <= 12) ? len : $urandom_range(6);
    // broken frame: cut short and abandoned by the next start
    if (n > 0 && $urandom_range(99) < 10) n = $urandom_range(n - 1);
    send_frame(4'($urandom_range(15)), $urandom_range(99) < 85, len, $urandom, n);
    if ($urandom_range(99) < 8) send_data(8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase();
    int unsigned goal;
    goal = frame_items + PHASE_ITEMS;
    while (frame_items < goal) send_random_frame();
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    send_idle_pct = 9;
    recv_idle_pct = 86;
    hold_off      = 0;
    frame_items   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: lone data, empty payload, all length forms and their edges,
    // refusals with a frame in progress, abandoned frames
    send_data(8'hFF);
    send_start(OPC_TEXT, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send_start(OPC_BINARY, 1'b0, 32'd3, 32'h0000_0000);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'($urandom_range(255)));
    send_start(OPC_CLOSE, 1'b1, 32'd125, 32'hA5C3_0F81);
    send_data(8'($urandom_range(255)));
    send_data(8'($urandom_range(255)));
    send_start(OPC_PONG, 1'b0, 32'd0, $urandom);
    send_data(8'($urandom_range(255)));
    send_start(OPC_BINARY, 1'b1, 32'd5, $urandom);
    send_data(8'($urandom_range(255)));
    send_start(OPC_PING, 1'b1, 32'd126, $urandom);
    send_data(8'($urandom_range(255)));
    send_frame(OPC_RESERVED_HI, 1'b1, 32'd126, $urandom, 1);
    send_frame(OPC_BINARY, 1'b1, 32'h0000_FFFF, $urandom, 1);
    send_frame(OPC_TEXT, 1'b0, 32'h0001_0000, $urandom, 1);
    send_frame(OPC_BINARY, 1'b1, 32'hFFFF_FFFF, $urandom, 1);
    send_frame(OPC_TEXT, 1'b1, 32'd1, $urandom, 1);
    drain();

    run_phase();

    send_idle_pct = 86;
    recv_idle_pct = 9;
    run_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = HOLD_CYCLES;
    run_phase();

    repeat (20) @(negedge clk);
    $display("covered %0d input transfers, %0d byte transfers out, %0d refused control frames",
             frame_items, chk_results, chk_refusals);
    $display("idle mixes 9/86, 86/9 and none, with a %0d-cycle output hold-off", HOLD_CYCLES);
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
